// File: sv/sdce_pkg.sv
`timescale 1ns / 1ps
// sdce_pkg: shared constants, codes and types of the static dictionary code expander
// no dependencies

package sdce_pkg;

    localparam int MAX_CODES   = 4096;
    localparam int CODE_AW     = $clog2(MAX_CODES);
    localparam int STORE_BYTES = 65536;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int BPR         = 8;
    localparam int LANE_W      = $clog2(BPR);
    localparam int ROWS        = STORE_BYTES / BPR;
    localparam int ROW_AW      = STORE_AW - LANE_W;

    localparam int DICT_W  = 13;
    localparam int CODE_W  = 16;
    localparam int LEN_W   = 8;
    localparam int POS_W   = LEN_W + 1;
    localparam int OUT_W   = 64;
    localparam int CNT_W   = 4;
    localparam int CFG_IW  = 1;
    localparam int CFG_DW  = 13;

    localparam logic [CODE_W-1:0] CODE_CLEAR  = CODE_W'(256);
    localparam logic [CODE_W-1:0] CODE_STOP   = CODE_W'(257);
    localparam logic [DICT_W-1:0] FIRST_ENTRY = DICT_W'(258);
    localparam logic [DICT_W-1:0] DICT_RESET  = DICT_W'(4096);

    localparam logic [CFG_IW-1:0] CFG_MODE = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_DICT = 1'b1;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_STREAM  = 2'd1,
        REQ_RESTART = 2'd2
    } t_req;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOOK  = 5'b00100,
        S_EMIT  = 5'b01000,
        S_SPARE = 5'b10000
    } t_state;

    typedef struct packed {
        logic                len_en;
        logic                off_en;
        logic [CODE_AW-1:0]  addr;
        logic [LEN_W-1:0]    len;
        logic [STORE_AW-1:0] off;
    } t_tbl_wr;

endpackage

// File: sv/sdce_if.sv
`timescale 1ns / 1ps
// sdce interfaces: input, output and configuration channels
// depends on sdce_pkg

interface sdce_in_if;
    import sdce_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] in_byte;
    modport source (output valid, req_type, in_byte, input ready);
    modport sink   (input valid, req_type, in_byte, output ready);
endinterface

interface sdce_out_if;
    import sdce_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] out_bytes;
    logic [CNT_W-1:0] out_count;
    logic             out_last;
    modport source (output valid, out_bytes, out_count, out_last, input ready);
    modport sink   (input valid, out_bytes, out_count, out_last, output ready);
endinterface

interface sdce_cfg_if;
    import sdce_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/static_dictionary_code_expander_core.sv
`timescale 1ns / 1ps
// static_dictionary_code_expander_core: top level, load and unpack control, expansion sequencer
// depends on sdce_pkg, sdce_if, sdce_table, sdce_store

// After reset the block clears its 4096-entry length table, one entry a cycle,
// and takes no item until that pass ends; configuration writes are always taken.
// Dictionary bytes, restarts, partial codes and literals are finished as they are taken.
// A code with a table string first reads the length and offset memories, then
// reads one 8-byte word per output word from the banked string store, waiting
// while the output stalls. One item is in work at a time.

module static_dictionary_code_expander_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdce_in_if.sink     i_in,
    sdce_out_if.source  o_out,
    sdce_cfg_if.sink    i_cfg
);
    import sdce_pkg::*;

    t_state r_state, n_state;

    logic                r_mode;
    logic [DICT_W-1:0]   r_dict_size;
    logic [DICT_W-1:0]   r_load_idx, n_load_idx;
    logic [LEN_W-1:0]    r_left, n_left;
    logic [STORE_AW-1:0] r_wp, n_wp;
    logic [STORE_AW-1:0] r_entry_off, n_entry_off;
    logic [1:0]          r_phase, n_phase;
    logic [7:0]          r_partial, n_partial;
    logic                r_ended, n_ended;

    logic [LEN_W-1:0]    r_len, n_len;
    logic [STORE_AW-1:0] r_off, n_off;
    logic [POS_W-1:0]    r_pos, n_pos;

    logic                r_out_valid, n_out_valid;
    logic [OUT_W-1:0]    r_out_bytes, n_out_bytes;
    logic [CNT_W-1:0]    r_out_count, n_out_count;
    logic                r_out_last, n_out_last;

    t_tbl_wr             tbl_wr;
    logic                tbl_re;
    logic [CODE_AW-1:0]  tbl_raddr;
    logic [LEN_W-1:0]    tbl_len;
    logic [STORE_AW-1:0] tbl_off;
    logic                tbl_busy;

    logic                st_we, st_re;
    logic [STORE_AW-1:0] st_rbase;
    logic [OUT_W-1:0]    st_word;

    logic                in_fire, out_free;
    logic [DICT_W-1:0]   limit;
    logic                code_ok;
    logic [CODE_W-1:0]   code;
    logic [POS_W-1:0]    rem, pos_next;
    logic [CNT_W-1:0]    cnt;
    logic [STORE_AW-1:0] wp_inc;

    sdce_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_en   (tbl_re),
        .i_rd_addr (tbl_raddr),
        .o_rd_len  (tbl_len),
        .o_rd_off  (tbl_off),
        .o_busy    (tbl_busy)
    );

    sdce_store u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_wp),
        .i_wdata (i_in.in_byte),
        .i_re    (st_re),
        .i_rbase (st_rbase),
        .o_word  (st_word)
    );

    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && out_free;
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign limit       = (r_dict_size > DICT_W'(MAX_CODES)) ? DICT_W'(MAX_CODES) : r_dict_size;
    assign wp_inc      = r_wp + 1'b1;

    assign o_out.valid     = r_out_valid;
    assign o_out.out_bytes = r_out_bytes;
    assign o_out.out_count = r_out_count;
    assign o_out.out_last  = r_out_last;

    // code unpacking
    always_comb begin
        n_phase   = r_phase;
        n_partial = r_partial;
        code_ok   = 1'b0;
        code      = '0;
        if (r_mode) begin
            if (r_phase == 2'd0) begin
                n_partial = i_in.in_byte;
                n_phase   = 2'd1;
            end else begin
                code    = {r_partial, i_in.in_byte};
                code_ok = 1'b1;
                n_phase = 2'd0;
            end
        end else begin
            case (r_phase)
                2'd1: begin
                    code      = CODE_W'({r_partial, i_in.in_byte[7:4]});
                    code_ok   = 1'b1;
                    n_partial = {4'd0, i_in.in_byte[3:0]};
                    n_phase   = 2'd2;
                end
                2'd2: begin
                    code    = CODE_W'({r_partial[3:0], i_in.in_byte});
                    code_ok = 1'b1;
                    n_phase = 2'd0;
                end
                default: begin
                    n_partial = i_in.in_byte;
                    n_phase   = 2'd1;
                end
            endcase
        end
    end

    assign rem      = POS_W'(r_len) - r_pos;
    assign cnt      = (rem > POS_W'(BPR)) ? CNT_W'(BPR) : CNT_W'(rem);
    assign pos_next = r_pos + POS_W'(BPR);

    always_comb begin
        n_state     = r_state;
        n_load_idx  = r_load_idx;
        n_left      = r_left;
        n_wp        = r_wp;
        n_entry_off = r_entry_off;
        n_ended     = r_ended;
        n_len       = r_len;
        n_off       = r_off;
        n_pos       = r_pos;
        n_out_valid = o_out.ready ? 1'b0 : r_out_valid;
        n_out_bytes = r_out_bytes;
        n_out_count = r_out_count;
        n_out_last  = r_out_last;
        tbl_wr      = '0;
        tbl_re      = 1'b0;
        tbl_raddr   = code[CODE_AW-1:0];
        st_we       = 1'b0;
        st_re       = 1'b0;
        st_rbase    = tbl_off;
        tbl_wr.addr = r_load_idx[CODE_AW-1:0];
        tbl_wr.off  = r_wp;

        case (r_state)
            S_CLEAR: begin
                if (!tbl_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    case (t_req'(i_in.req_type))
                        REQ_RESTART: begin
                            n_load_idx = FIRST_ENTRY;
                            n_left     = '0;
                            n_wp       = '0;
                            n_ended    = 1'b0;
                        end
                        REQ_LOAD: begin
                            if (r_load_idx < limit) begin
                                if (r_left == '0) begin
                                    tbl_wr.off_en = 1'b1;
                                    tbl_wr.len_en = 1'b1;
                                    n_entry_off   = r_wp;
                                    if (i_in.in_byte == 8'd0) begin
                                        n_load_idx = r_load_idx + 1'b1;
                                    end else begin
                                        n_left = i_in.in_byte;
                                    end
                                end else begin
                                    st_we  = 1'b1;
                                    n_wp   = wp_inc;
                                    n_left = r_left - 1'b1;
                                    if (r_left == LEN_W'(1)) begin
                                        tbl_wr.len_en = 1'b1;
                                        tbl_wr.len    = LEN_W'(wp_inc - r_entry_off);
                                        n_load_idx    = r_load_idx + 1'b1;
                                    end
                                end
                            end
                        end
                        REQ_STREAM: begin
                            if (!r_ended && code_ok) begin
                                if (code == CODE_STOP) begin
                                    n_ended = 1'b1;
                                end else if (code < CODE_CLEAR) begin
                                    n_out_valid = 1'b1;
                                    n_out_bytes = OUT_W'(code[7:0]);
                                    n_out_count = CNT_W'(1);
                                    n_out_last  = 1'b1;
                                end else if (code != CODE_CLEAR
                                             && code < CODE_W'(limit)) begin
                                    tbl_re  = 1'b1;
                                    n_state = S_LOOK;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOOK: begin
                n_len = tbl_len;
                n_off = tbl_off;
                n_pos = '0;
                if (tbl_len == '0) begin
                    n_state = S_IDLE;
                end else begin
                    st_re    = 1'b1;
                    st_rbase = tbl_off;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = cnt;
                    n_out_last  = (rem <= POS_W'(BPR));
                    for (int k = 0; k < BPR; k++) begin
                        n_out_bytes[8*k +: 8] = (CNT_W'(k) < cnt) ? st_word[8*k +: 8] : 8'd0;
                    end
                    if (rem <= POS_W'(BPR)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos    = pos_next;
                        st_re    = 1'b1;
                        st_rbase = r_off + STORE_AW'(pos_next);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_mode      <= 1'b0;
            r_dict_size <= DICT_RESET;
            r_load_idx  <= FIRST_ENTRY;
            r_left      <= '0;
            r_wp        <= '0;
            r_phase     <= '0;
            r_partial   <= '0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_idx  <= n_load_idx;
            r_left      <= n_left;
            r_wp        <= n_wp;
            r_ended     <= n_ended;
            r_out_valid <= n_out_valid;
            if (in_fire && t_req'(i_in.req_type) == REQ_RESTART) begin
                r_phase   <= '0;
                r_partial <= '0;
            end else if (in_fire && t_req'(i_in.req_type) == REQ_STREAM && !r_ended) begin
                r_phase   <= n_phase;
                r_partial <= n_partial;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_MODE: r_mode      <= i_cfg.data[0];
                    CFG_DICT: r_dict_size <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry_off <= n_entry_off;
        r_len       <= n_len;
        r_off       <= n_off;
        r_pos       <= n_pos;
        r_out_bytes <= n_out_bytes;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
    end

endmodule

// File: sv/sdce_table.sv
`timescale 1ns / 1ps
// sdce_table: entry length and offset memories, length cleared by a pass after reset
// depends on sdce_pkg

module sdce_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sdce_pkg::t_tbl_wr             i_wr,
    input  logic                          i_rd_en,
    input  logic [sdce_pkg::CODE_AW-1:0]  i_rd_addr,
    output logic [sdce_pkg::LEN_W-1:0]    o_rd_len,
    output logic [sdce_pkg::STORE_AW-1:0] o_rd_off,
    output logic                          o_busy
);
    import sdce_pkg::*;

    logic [LEN_W-1:0]    len_mem [MAX_CODES];
    logic [STORE_AW-1:0] off_mem [MAX_CODES];

    logic               r_clearing;
    logic [CODE_AW-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == CODE_AW'(MAX_CODES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            len_mem[r_clr_idx] <= '0;
        end else if (i_wr.len_en) begin
            len_mem[i_wr.addr] <= i_wr.len;
        end
        if (i_rd_en) begin
            o_rd_len <= len_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.off_en) begin
            off_mem[i_wr.addr] <= i_wr.off;
        end
        if (i_rd_en) begin
            o_rd_off <= off_mem[i_rd_addr];
        end
    end

    assign o_busy = r_clearing;

endmodule

// File: sv/sdce_store.sv
`timescale 1ns / 1ps
// sdce_store: string store in byte banks, one byte written, one aligned-free word read
// depends on sdce_pkg

module sdce_store (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [sdce_pkg::STORE_AW-1:0] i_waddr,
    input  logic [7:0]                    i_wdata,
    input  logic                          i_re,
    input  logic [sdce_pkg::STORE_AW-1:0] i_rbase,
    output logic [sdce_pkg::OUT_W-1:0]    o_word
);
    import sdce_pkg::*;

    logic [7:0]        bank_q [BPR];
    logic [LANE_W-1:0] r_lo;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_lo <= i_rbase[LANE_W-1:0];
        end
    end

    for (genvar j = 0; j < BPR; j++) begin : g_bank
        logic [7:0]        mem [ROWS];
        logic [ROW_AW-1:0] rrow;

        assign rrow = i_rbase[STORE_AW-1:LANE_W]
                      + ROW_AW'((LANE_W'(j) < i_rbase[LANE_W-1:0]) ? 1 : 0);

        always_ff @(posedge i_clk) begin
            if (i_we && i_waddr[LANE_W-1:0] == LANE_W'(j)) begin
                mem[i_waddr[STORE_AW-1:LANE_W]] <= i_wdata;
            end
            if (i_re) begin
                bank_q[j] <= mem[rrow];
            end
        end
    end

    always_comb begin
        o_word = '0;
        for (int k = 0; k < BPR; k++) begin
            o_word[8*k +: 8] = bank_q[LANE_W'(r_lo + LANE_W'(k))];
        end
    end

endmodule

// File: sim/sdce_checker.sv
`timescale 1ns / 1ps
// sdce_checker: watches the input, output and configuration channels of the expander,
// predicts the decoded words and compares them; depends on sdce_pkg and sdce_if

module sdce_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdce_in_if          i_in,
    sdce_out_if         i_out,
    sdce_cfg_if         i_cfg,
    output int          o_fail_count,
    output int          o_pending
);
    import sdce_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] bytes;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_word;

    logic [LEN_W-1:0]    len_tbl [MAX_CODES];
    logic [STORE_AW-1:0] off_tbl [MAX_CODES];
    logic [7:0]          store   [STORE_BYTES];
    logic [DICT_W-1:0]   load_idx;
    logic [LEN_W-1:0]    load_left;
    logic [STORE_AW-1:0] wr_ptr;
    logic [1:0]          phase;
    logic [15:0]         partial;
    logic                ended;
    logic                wide_mode;
    logic [DICT_W-1:0]   dict_size;
    t_word               expected_words[$];

    assign o_pending = expected_words.size();

    function automatic int table_limit();
        return (int'(dict_size) > MAX_CODES) ? MAX_CODES : int'(dict_size);
    endfunction

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic load_dict_byte(input logic [7:0] b);
        int idx;
        idx = int'(load_idx);
        if (idx >= table_limit()) return;
        if (load_left == '0) begin
            off_tbl[idx] = wr_ptr;
            len_tbl[idx] = '0;
            if (b == 8'd0) load_idx = load_idx + 1'b1;
            else load_left = b;
            return;
        end
        store[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        load_left = load_left - 1'b1;
        if (load_left == '0) begin
            len_tbl[idx] = LEN_W'(wr_ptr - off_tbl[idx]);
            load_idx = load_idx + 1'b1;
        end
    endtask

    task automatic expand_code(input int code);
        t_word w;
        int len, pos, cnt;
        if (code < int'(CODE_CLEAR)) begin
            w.bytes = OUT_W'(code);
            w.count = CNT_W'(1);
            w.last = 1'b1;
            expected_words.push_back(w);
            return;
        end
        if (code == int'(CODE_CLEAR) || code >= table_limit()) return;
        len = int'(len_tbl[code]);
        for (pos = 0; pos < len; pos += BPR) begin
            cnt = (len - pos > BPR) ? BPR : len - pos;
            w.bytes = '0;
            for (int k = 0; k < cnt; k++)
                w.bytes[8*k +: 8] = store[STORE_AW'(int'(off_tbl[code]) + pos + k)];
            w.count = CNT_W'(cnt);
            w.last = (pos + cnt >= len);
            expected_words.push_back(w);
        end
    endtask

    task automatic take_item(input logic [1:0] t, input logic [7:0] b);
        int code;
        if (t == REQ_RESTART) begin
            load_idx = FIRST_ENTRY;
            load_left = '0;
            wr_ptr = '0;
            phase = '0;
            partial = '0;
            ended = 1'b0;
            return;
        end
        if (t == REQ_LOAD) begin
            load_dict_byte(b);
            return;
        end
        if (t != REQ_STREAM || ended) return;
        if (wide_mode) begin
            if (phase == 2'd0) begin
                partial = 16'(b);
                phase = 2'd1;
                return;
            end
            code = int'({partial[7:0], b});
            phase = 2'd0;
        end else begin
            if (phase == 2'd1) begin
                code = int'({partial[7:0], b[7:4]});
                partial = 16'(b[3:0]);
                phase = 2'd2;
            end else if (phase == 2'd2) begin
                code = int'({partial[3:0], b});
                phase = 2'd0;
            end else begin
                partial = 16'(b);
                phase = 2'd1;
                return;
            end
        end
        if (code == int'(CODE_STOP)) begin
            ended = 1'b1;
            return;
        end
        expand_code(code);
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CODES; i++) len_tbl[i] = '0;
            load_idx = FIRST_ENTRY;
            load_left = '0;
            wr_ptr = '0;
            phase = '0;
            partial = '0;
            ended = 1'b0;
            wide_mode = 1'b0;
            dict_size = DICT_RESET;
            expected_words.delete();
            o_fail_count = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_words.size() == 0) begin
                    report("word with none expected");
                end else begin
                    w = expected_words.pop_front();
                    if (i_out.out_bytes !== w.bytes)
                        report($sformatf("out_bytes %h want %h", i_out.out_bytes, w.bytes));
                    if (i_out.out_count !== w.count)
                        report($sformatf("out_count %0d want %0d", i_out.out_count, w.count));
                    if (i_out.out_last !== w.last)
                        report($sformatf("out_last %b want %b", i_out.out_last, w.last));
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_MODE) wide_mode = i_cfg.data[0];
                else if (i_cfg.index == CFG_DICT) dict_size = i_cfg.data;
            end
            if (i_in.valid && i_in.ready) take_item(i_in.req_type, i_in.in_byte);
        end
    end

endmodule

// File: sim/static_dictionary_code_expander_core_tb.sv
`timescale 1ns / 1ps
// static_dictionary_code_expander_core_tb: stimulus, idling and verdict for the expander
// depends on sdce_pkg, sdce_if, sdce_checker and the core

module static_dictionary_code_expander_core_tb;
    import sdce_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    logic in_acc = 1'b0;
    logic cfg_acc = 1'b0;

    sdce_in_if  in_ch();
    sdce_out_if out_ch();
    sdce_cfg_if cfg_ch();

    static_dictionary_code_expander_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch), .i_cfg(cfg_ch)
    );

    sdce_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch), .i_cfg(cfg_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stall pattern
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) out_ch.ready = ($urandom_range(0, 2) != 0);
            else if ($urandom_range(0, 30) == 0) out_ch.ready = 1'b0;
            else out_ch.ready = 1'b1;
        end
    end

    // accepts seen at the rising edge
    always @(posedge i_clk) begin
        in_acc  <= in_ch.valid && in_ch.ready;
        cfg_acc <= cfg_ch.valid && cfg_ch.ready;
    end

    // watchdog on accepts; covers the clearing pass after reset
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send(input t_req t, input logic [7:0] b);
        int g;
        g = gap_len();
        repeat (g) @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.req_type = t;
        in_ch.in_byte = b;
        do @(negedge i_clk); while (!in_acc);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] d);
        drain();
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = d;
        do @(negedge i_clk); while (!cfg_acc);
        cfg_ch.valid = 1'b0;
    endtask

    // load entries 258.. with random lengths; long ones now and then
    task automatic load_dict(input int entries);
        int len;
        send(REQ_RESTART, 8'($urandom));
        for (int e = 0; e < entries; e++) begin
            case ($urandom_range(0, 9))
                0: len = 0;
                1: len = $urandom_range(17, 40);
                default: len = $urandom_range(1, 12);
            endcase
            send(REQ_LOAD, 8'(len));
            for (int k = 0; k < len; k++) send(REQ_LOAD, 8'($urandom));
        end
    endtask

    task automatic send_code(input logic wide, input logic [15:0] c);
        if (wide) begin
            send(REQ_STREAM, c[15:8]);
            send(REQ_STREAM, c[7:0]);
        end else begin
            send(REQ_STREAM, c[11:4]);
            send(REQ_STREAM, {c[3:0], 4'($urandom)});
        end
    endtask

    function automatic logic [15:0] pick_code(input int entries);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 16'($urandom_range(0, 255));
        if (r < 8) return 16'(258 + $urandom_range(0, entries));
        if (r == 8) return CODE_CLEAR;
        return 16'($urandom);
    endfunction

    task automatic stream_phase(input logic wide, input int entries, input int codes);
        logic [15:0] c;
        send(REQ_RESTART, 8'h00);
        for (int i = 0; i < codes; i++) begin
            c = pick_code(entries);
            if (!wide) c[15:12] = 4'($urandom);
            if (c == CODE_STOP || (!wide && c[11:0] == CODE_STOP[11:0])) c = 16'd65;
            if ($urandom_range(0, 15) == 0)
                send(t_req'($urandom_range(0, 3)), 8'($urandom));
            else
                send_code(wide, c);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.req_type = REQ_LOAD;
        in_ch.in_byte = 8'h00;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_MODE;
        cfg_ch.data = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: literals, clear, unloaded, loads and table codes, undefined request, stop, ignored after stop
        send_code(1'b0, 16'h000);
        send_code(1'b0, 16'h0ff);
        send_code(1'b0, CODE_CLEAR);
        send_code(1'b0, 16'hfff);
        send(REQ_LOAD, 8'd3);
        send(REQ_LOAD, 8'haa);
        send(REQ_LOAD, 8'h55);
        send(REQ_LOAD, 8'hff);
        send(REQ_LOAD, 8'd0);
        send(REQ_LOAD, 8'd37);
        for (int k = 0; k < 37; k++) send(REQ_LOAD, 8'(k ^ 8'h5a));
        send_code(1'b0, 16'd258);
        send_code(1'b0, 16'd259);
        send_code(1'b0, 16'd260);
        send(t_req'(2'd3), 8'h12);
        send(REQ_STREAM, 8'h10);
        send(REQ_STREAM, 8'h10);
        send(REQ_STREAM, 8'h10);
        send(REQ_STREAM, 8'h02);
        send(REQ_STREAM, 8'h34);

        // wide mode, including a switch in the middle of a code
        send(REQ_RESTART, 8'h00);
        send(REQ_STREAM, 8'h01);
        write_reg(CFG_MODE, 13'd1);
        send(REQ_STREAM, 8'h02);
        send_code(1'b1, 16'hffff);
        send_code(1'b1, 16'h00ab);

        // small table: loads past it and codes at or past its end are dropped
        write_reg(CFG_DICT, 13'd258);
        send(REQ_RESTART, 8'h00);
        send(REQ_LOAD, 8'd1);
        send(REQ_LOAD, 8'h77);
        send_code(1'b1, 16'd258);
        write_reg(CFG_DICT, 13'h1fff);
        send_code(1'b1, 16'd258);

        for (int p = 0; p < 3; p++) begin
            int entries;
            logic wide;
            entries = $urandom_range(2, 5);
            wide = $urandom_range(0, 1);
            write_reg(CFG_MODE, CFG_DW'(wide));
            write_reg(CFG_DICT, (p == 2) ? 13'd258 : CFG_DW'($urandom_range(262, 4096)));
            load_dict(entries);
            if (p == 1) drain();
            stream_phase(wide, entries, 12);
        end

        drain();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
